[src/assert_macros.svh]
// Assertion macros used by the checker file of the signature parser.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/dsp_pkg.sv]
// Package for the DER signature pair parser: codes, queue entry type, sizes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package dsp_pkg;

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;

  // parser phases
  localparam logic [2:0] PH_SEQ_TAG = 3'd0;
  localparam logic [2:0] PH_SEQ_LEN = 3'd1;
  localparam logic [2:0] PH_INT_TAG = 3'd2;
  localparam logic [2:0] PH_INT_LEN = 3'd3;
  localparam logic [2:0] PH_INT_VAL = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;
  localparam logic [2:0] PH_ERR_MAL = 3'd6;
  localparam logic [2:0] PH_ERR_NI  = 3'd7;

  // frame status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_NOTIMPL   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_R      = 2'd0;
  localparam logic [1:0] KIND_S      = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam int DSP_FIFO_DEPTH = 4;

  // one queue entry: at most a value byte and a status per input item
  typedef struct packed {
    logic       val_vld;
    logic       which;
    logic [7:0] val;
    logic       st_vld;
    logic [1:0] st;
  } dsp_entry_t;

endpackage
`default_nettype wire

[src/dsp_front.sv]
// Front end: accepts frame bytes, runs the DER parse state and builds queue entries.
// Depends on dsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dsp_front
  import dsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] in_byte,
  input  wire logic       frame_end,
  output logic            push,
  output dsp_entry_t      entry
);

  logic [2:0] phase_r, phase_nxt;
  logic [6:0] seq_left_r, seq_left_nxt;
  logic [6:0] int_left_r, int_left_nxt;
  logic       strip_r, strip_nxt;
  logic       which_r, which_nxt;
  logic       swallow_r, swallow_nxt;

  always_comb begin
    phase_nxt    = phase_r;
    seq_left_nxt = seq_left_r;
    int_left_nxt = int_left_r;
    strip_nxt    = strip_r;
    which_nxt    = which_r;
    swallow_nxt  = swallow_r;
    entry        = '0;

    if (swallow_r) begin
      // strip flag doubles as "sequence length still being counted"
      if (strip_r) begin
        if (seq_left_r == 7'd0) phase_nxt = PH_ERR_MAL;
        else seq_left_nxt = seq_left_r - 7'd1;
      end
    end else if (phase_r == PH_SEQ_TAG) begin
      if (in_byte != TAG_SEQUENCE) begin
        swallow_nxt = 1'b1; phase_nxt = PH_ERR_MAL; strip_nxt = 1'b0;
      end else begin
        phase_nxt = PH_SEQ_LEN;
      end
    end else if (phase_r == PH_SEQ_LEN) begin
      if (in_byte[7]) begin
        swallow_nxt = 1'b1; phase_nxt = PH_ERR_NI; strip_nxt = 1'b0;
      end else begin
        seq_left_nxt = in_byte[6:0];
        phase_nxt    = PH_INT_TAG;
      end
    end else if (seq_left_r == 7'd0) begin
      swallow_nxt = 1'b1; phase_nxt = PH_ERR_MAL; strip_nxt = 1'b0;
    end else begin
      seq_left_nxt = seq_left_r - 7'd1;
      unique case (phase_r)
        PH_INT_TAG: begin
          if (in_byte != TAG_INTEGER) begin
            swallow_nxt = 1'b1; phase_nxt = PH_ERR_MAL; strip_nxt = 1'b1;
          end else begin
            phase_nxt = PH_INT_LEN;
          end
        end
        PH_INT_LEN: begin
          if (in_byte[7]) begin
            swallow_nxt = 1'b1; phase_nxt = PH_ERR_NI; strip_nxt = 1'b1;
          end else if (in_byte == 8'd0 || in_byte[6:0] > seq_left_nxt) begin
            swallow_nxt = 1'b1; phase_nxt = PH_ERR_MAL; strip_nxt = 1'b1;
          end else begin
            int_left_nxt = in_byte[6:0];
            strip_nxt    = 1'b1;
            phase_nxt    = PH_INT_VAL;
          end
        end
        PH_INT_VAL: begin
          int_left_nxt = int_left_r - 7'd1;
          // the final byte of an integer is always sent, even if zero
          if (!(strip_r && in_byte == 8'd0 && int_left_nxt != 7'd0)) begin
            strip_nxt     = 1'b0;
            entry.val_vld = 1'b1;
            entry.which   = which_r;
            entry.val     = in_byte;
          end
          if (int_left_nxt == 7'd0) begin
            strip_nxt = 1'b0;
            if (!which_r) begin
              which_nxt = 1'b1;
              phase_nxt = PH_INT_TAG;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end
        default: begin
          // done but bytes still declared: size mismatch
          swallow_nxt = 1'b1; phase_nxt = PH_ERR_MAL; strip_nxt = 1'b0;
        end
      endcase
    end

    if (frame_end) begin
      entry.st_vld = 1'b1;
      if (swallow_nxt) begin
        if (strip_nxt && seq_left_nxt != 7'd0) entry.st = ST_MALFORMED;
        else if (phase_nxt == PH_ERR_NI)       entry.st = ST_NOTIMPL;
        else                                   entry.st = ST_MALFORMED;
      end else if (phase_nxt == PH_DONE && seq_left_nxt == 7'd0) begin
        entry.st = ST_OK;
      end else begin
        entry.st = ST_MALFORMED;
      end
      phase_nxt    = PH_SEQ_TAG;
      seq_left_nxt = 7'd0;
      int_left_nxt = 7'd0;
      strip_nxt    = 1'b0;
      which_nxt    = 1'b0;
      swallow_nxt  = 1'b0;
    end
  end

  assign push = acc && (entry.val_vld || entry.st_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SEQ_TAG;
      seq_left_r <= 7'd0;
      int_left_r <= 7'd0;
      strip_r    <= 1'b0;
      which_r    <= 1'b0;
      swallow_r  <= 1'b0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      seq_left_r <= seq_left_nxt;
      int_left_r <= int_left_nxt;
      strip_r    <= strip_nxt;
      which_r    <= which_nxt;
      swallow_r  <= swallow_nxt;
    end
  end

endmodule
`default_nettype wire

[src/dsp_fifo.sv]
// Short queue of parse entries between the front end and the result stage.
// Depends on dsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dsp_fifo
  import dsp_pkg::*;
#(
  parameter int DEPTH = DSP_FIFO_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  dsp_entry_t wr_entry,
  input  wire logic pop,
  output logic      full,
  output logic      nempty,
  output dsp_entry_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dsp_entry_t      mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full   = (count_r == CW'(DEPTH));
  assign nempty = (count_r != '0);
  assign head   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_entry;
  end

endmodule
`default_nettype wire

[src/dsp_back.sv]
// Result stage: splits queue entries into value-byte and status items on the output.
// Depends on dsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dsp_back
  import dsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_nempty,
  input  dsp_entry_t       q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  dsp_entry_t  work_r, work_nxt, work_after;
  logic        oval_r, oval_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic        olast_r, olast_nxt;
  logic        out_free, take;

  assign out_free = !oval_r || out_tready;
  assign take     = out_free && (work_r.val_vld || work_r.st_vld);

  always_comb begin
    work_after = work_r;
    okind_nxt  = okind_r;
    obyte_nxt  = obyte_r;
    ost_nxt    = ost_r;
    olast_nxt  = olast_r;
    oval_nxt   = oval_r && !out_tready;
    if (take) begin
      oval_nxt = 1'b1;
      if (work_r.val_vld) begin
        okind_nxt          = work_r.which ? KIND_S : KIND_R;
        obyte_nxt          = work_r.val;
        ost_nxt            = ST_OK;
        olast_nxt          = 1'b0;
        work_after.val_vld = 1'b0;
      end else begin
        okind_nxt         = KIND_STATUS;
        obyte_nxt         = 8'd0;
        ost_nxt           = work_r.st;
        olast_nxt         = 1'b1;
        work_after.st_vld = 1'b0;
      end
    end
    // refill the working entry once it is about to run dry
    q_pop    = q_nempty && !work_after.val_vld && !work_after.st_vld;
    work_nxt = q_pop ? q_head : work_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r.val_vld <= 1'b0;
      work_r.st_vld  <= 1'b0;
      oval_r         <= 1'b0;
    end else begin
      work_r         <= work_nxt;
      oval_r         <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    okind_r      <= okind_nxt;
    obyte_r      <= obyte_nxt;
    ost_r        <= ost_nxt;
    olast_r      <= olast_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = {6'd0, ost_r, obyte_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

[src/der_signature_pair_parser.sv]
// An accepted item goes through the queue, the working entry and the output registers to out_*.
// Throughput: one item per cycle while out_tready is high and items give at most one
// result each; the final byte of a frame can give a value byte and a status, which leave
// as two output items, absorbed by the FIFO_DEPTH-entry queue between parser and result stage.
// Reset: synchronous, active low; parser returns to expecting a sequence tag, queue empties.
`timescale 1ns / 1ps
`default_nettype none
module der_signature_pair_parser
  import dsp_pkg::*;
#(
  parameter int FIFO_DEPTH = DSP_FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // frame_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] value_byte, [9:8] status, rest zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // run_last
);

  logic       acc, push, q_full, q_nempty, q_pop;
  dsp_entry_t entry, q_head;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  dsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_byte   (in_tdata),
    .frame_end (in_tlast),
    .push      (push),
    .entry     (entry)
  );

  dsp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (entry),
    .pop      (q_pop),
    .full     (q_full),
    .nempty   (q_nempty),
    .head     (q_head)
  );

  dsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nempty   (q_nempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

[src/dsp_checker.sv]
// Port-level checks on the output channel of the signature parser, with its bind.
// Depends on dsp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dsp_checker
  import dsp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // tlast marks exactly the status items
  `ASSERT_IMPL(a_last_is_status, clk, rst_n, out_tvalid, out_tlast == (out_tuser == KIND_STATUS))
  // value bytes carry a zero status, status items a zero byte
  `ASSERT_IMPL(a_field_zero, clk, rst_n, out_tvalid, (out_tlast ? (out_tdata[7:0] == 8'd0) : (out_tdata[9:8] == ST_OK)))
  // status code in range and padding clear
  `ASSERT_IMPL(a_status_range, clk, rst_n, out_tvalid, out_tdata[9:8] != 2'd3 && out_tdata[15:10] == 6'd0)
  // a stalled item holds
  `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind der_signature_pair_parser dsp_checker u_dsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
